// ===== rtl/clap_transient_detector_defines.svh =====
// Assertion helpers for the clap transient detector.
`ifndef CLAP_TRANSIENT_DETECTOR_DEFINES_SVH
`define CLAP_TRANSIENT_DETECTOR_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define CTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctd_pkg.sv =====
`timescale 1ns / 1ps

package ctd_pkg;

    // Register file geometry
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int EMA_BITS     = 16;
    localparam int OUT_TIME_BITS = 32;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_EMA_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPIKE_THR    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_DECAY_THR    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_DECAY_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_CALIB        = 3'd4;

    // Register reset values
    localparam logic [CFG_BITS-1:0] RST_EMA_FACTOR    = 16'd655;
    localparam logic [CFG_BITS-1:0] RST_SPIKE_THR     = 16'd8000;
    localparam logic [CFG_BITS-1:0] RST_DECAY_THR     = 16'd2000;
    localparam logic [CFG_BITS-1:0] RST_DECAY_TIMEOUT = 16'd50;
    localparam logic [CFG_BITS-1:0] RST_CALIB         = 16'd1024;

    // Half of one unit of the Q0.16 weight product, for round to nearest
    localparam logic [EMA_BITS-1:0] EMA_ROUND_HALF = 16'h8000;

    typedef struct packed {
        logic [CFG_BITS-1:0] ema_factor;
        logic [CFG_BITS-1:0] spike_threshold;
        logic [CFG_BITS-1:0] decay_threshold;
        logic [CFG_BITS-1:0] decay_timeout_ms;
        logic [CFG_BITS-1:0] calib_samples;
    } t_cfg_regs;

endpackage

// ===== rtl/ctd_sample_if.sv =====
`timescale 1ns / 1ps

// Sample channel: one audio sample and its timestamp per request.
interface ctd_sample_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   time_ms;

    modport source (output valid, output sample, output time_ms, input ready);
    modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

// ===== rtl/ctd_event_if.sv =====
`timescale 1ns / 1ps

// Event channel: one detected clap per request.
interface ctd_event_if;
    logic                              valid;
    logic                              ready;
    logic [ctd_pkg::OUT_TIME_BITS-1:0] spike_time_ms;

    modport source (output valid, output spike_time_ms, input ready);
    modport sink   (input valid, input spike_time_ms, output ready);
endinterface

// ===== rtl/clap_transient_detector.sv =====
`timescale 1ns / 1ps
// Clap transient detector.
// Sample channel (i_smp): one signed PCM sample with its wrapping millisecond
// timestamp per request. Event channel (o_evt): one request per detected clap,
// carrying the timestamp of the spike that started it. Register port: write
// i_cfg_data into register i_cfg_idx when i_cfg_we is high; write only while
// no samples are in flight.
// A sample passes from the input register through the update stage into
// the event register. Throughput: one sample per cycle while the receiver does
// not stall. The update of the moving average baseline (subtract, magnitude,
// one 33x16 multiply, round and add) is combinational and sets the clock limit,
// since the next sample needs the new baseline.
// Reset clears the baseline, the detector state and the calibration count and
// loads the register defaults; the first sample after reset seeds the baseline.
// When the receiver stalls, the event register holds its request and the
// update stage waits; the sample channel keeps taking one more sample into the
// input register and then drops ready until the event is taken.
`include "clap_transient_detector_defines.svh"

module clap_transient_detector #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16,
    parameter int TIME_BITS     = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ctd_sample_if.sink                       i_smp,
    ctd_event_if.source                      o_evt,
    input  logic                             i_cfg_we,
    input  logic [ctd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [ctd_pkg::CFG_BITS-1:0]     i_cfg_data
);

    localparam int BW = SAMPLE_BITS + FRACTION_BITS;        // baseline width
    localparam int DW = BW + 1;                             // difference width
    localparam int MW = DW + ctd_pkg::EMA_BITS;             // product width
    localparam int TW = ctd_pkg::CFG_BITS + FRACTION_BITS;  // scaled threshold
    localparam int CW = (DW > TW) ? DW : TW;                // compare width
    localparam int ET = (TIME_BITS > ctd_pkg::OUT_TIME_BITS) ?
                        TIME_BITS : ctd_pkg::OUT_TIME_BITS;

    // Registers
    ctd_pkg::t_cfg_regs           r_cfg;
    logic                         r_in_valid;
    logic [SAMPLE_BITS-1:0]       r_sample;
    logic [TIME_BITS-1:0]         r_time;
    logic [BW-1:0]                r_baseline;
    logic                         r_armed;
    logic [TIME_BITS-1:0]         r_spike_time;
    logic [DW-1:0]                r_spike_dev;
    logic [ctd_pkg::CFG_BITS-1:0] r_calib_left;
    logic                         r_seeded;
    logic                         r_out_valid;
    logic [ctd_pkg::OUT_TIME_BITS-1:0] r_out_time;

    // Next values
    logic [BW-1:0]                n_baseline;
    logic [ctd_pkg::CFG_BITS-1:0] n_calib_left;

    logic                         w_fire;
    logic [DW-1:0]                w_scaled;
    logic [DW-1:0]                w_base_ext;
    logic [DW-1:0]                w_diff;
    logic [DW-1:0]                w_mag;
    logic [MW-1:0]                w_prod;
    logic [MW-1:0]                w_round;
    logic [DW-1:0]                w_step;
    logic [DW-1:0]                w_base_next;
    logic [CW-1:0]                w_dev_cmp;
    logic [CW-1:0]                w_spike_lim;
    logic [CW-1:0]                w_decay_lim;
    logic [TIME_BITS-1:0]         w_elapsed;
    logic                         w_active;
    logic                         w_arm;
    logic                         w_cancel;
    logic                         w_clap;
    logic [ET-1:0]                w_time_ext;

    // Handshake: the update stage runs when it holds a sample and the event
    // register is free or being emptied.
    assign w_fire      = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_smp.ready = !r_in_valid || w_fire;
    assign o_evt.valid = r_out_valid;
    assign o_evt.spike_time_ms = r_out_time;

    // Deviation of the sample from the baseline, shared with the average update
    assign w_scaled   = {r_sample[SAMPLE_BITS-1], r_sample, {FRACTION_BITS{1'b0}}};
    assign w_base_ext = {r_baseline[BW-1], r_baseline};
    assign w_diff     = w_scaled - w_base_ext;
    assign w_mag      = w_diff[DW-1] ? (DW'(0) - w_diff) : w_diff;

    // Baseline step: round(|d| * weight / 2^16), ties away from zero
    assign w_prod      = MW'(w_mag) * MW'(r_cfg.ema_factor);
    assign w_round     = w_prod + MW'(ctd_pkg::EMA_ROUND_HALF);
    assign w_step      = w_round[MW-1 -: DW];
    assign w_base_next = w_diff[DW-1] ? (w_base_ext - w_step) : (w_base_ext + w_step);

    // Thresholds scaled into baseline units
    assign w_dev_cmp   = CW'(w_mag);
    assign w_spike_lim = CW'({r_cfg.spike_threshold, {FRACTION_BITS{1'b0}}});
    assign w_decay_lim = CW'({r_cfg.decay_threshold, {FRACTION_BITS{1'b0}}});
    assign w_elapsed   = r_time - r_spike_time;

    // Detector decisions
    assign w_active = r_seeded && (r_calib_left == '0);
    assign w_arm    = w_active && !r_armed && (w_dev_cmp > w_spike_lim);
    assign w_cancel = w_active && r_armed && (w_mag > r_spike_dev);
    assign w_clap   = w_active && r_armed && !w_cancel
                      && (w_elapsed >= TIME_BITS'(r_cfg.decay_timeout_ms))
                      && (w_dev_cmp < w_decay_lim);
    assign w_time_ext = ET'(r_spike_time);

    // Seed the baseline and the calibration count on the first sample, else take the averaged value and count down
    always_comb begin
        n_baseline   = r_baseline;
        n_calib_left = r_calib_left;
        if (!r_seeded) begin
            n_baseline   = w_scaled[BW-1:0];
            n_calib_left = (r_cfg.calib_samples == '0) ? '0 : r_cfg.calib_samples - 1'b1;
        end else begin
            n_baseline = w_base_next[BW-1:0];
            if (r_calib_left != '0) begin
                n_calib_left = r_calib_left - 1'b1;
            end
        end
    end

    // Write the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_factor       <= ctd_pkg::RST_EMA_FACTOR;
            r_cfg.spike_threshold  <= ctd_pkg::RST_SPIKE_THR;
            r_cfg.decay_threshold  <= ctd_pkg::RST_DECAY_THR;
            r_cfg.decay_timeout_ms <= ctd_pkg::RST_DECAY_TIMEOUT;
            r_cfg.calib_samples    <= ctd_pkg::RST_CALIB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ctd_pkg::CFG_IDX_EMA_FACTOR:    r_cfg.ema_factor       <= i_cfg_data;
                ctd_pkg::CFG_IDX_SPIKE_THR:     r_cfg.spike_threshold  <= i_cfg_data;
                ctd_pkg::CFG_IDX_DECAY_THR:     r_cfg.decay_threshold  <= i_cfg_data;
                ctd_pkg::CFG_IDX_DECAY_TIMEOUT: r_cfg.decay_timeout_ms <= i_cfg_data;
                ctd_pkg::CFG_IDX_CALIB:         r_cfg.calib_samples    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Capture the sample request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_sample <= i_smp.sample;
            r_time   <= i_smp.time_ms;
        end
    end

    // Advance the detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline   <= '0;
            r_armed      <= 1'b0;
            r_spike_time <= '0;
            r_spike_dev  <= '0;
            r_calib_left <= '0;
            r_seeded     <= 1'b0;
        end else if (w_fire) begin
            r_baseline   <= n_baseline;
            r_calib_left <= n_calib_left;
            r_seeded     <= 1'b1;
            if (w_arm) begin
                r_armed      <= 1'b1;
                r_spike_time <= r_time;
                r_spike_dev  <= w_mag;
            end else if (w_cancel || w_clap) begin
                r_armed      <= 1'b0;
                r_spike_time <= '0;
            end
        end
    end

    // Hold the event until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_clap;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_clap) begin
            r_out_time <= w_time_ext[ctd_pkg::OUT_TIME_BITS-1:0];
        end
    end

    // Checks
    `CTD_ASSERT_NEXT(a_clap_raises_event, i_clk, i_rst_n, w_fire && w_clap, r_out_valid, "clap lost before event register")
    `CTD_ASSERT_NOW(a_clap_needs_armed, i_clk, i_rst_n, w_clap, r_armed && !w_arm, "clap while idle")
    `CTD_ASSERT_NOW(a_calib_after_seed, i_clk, i_rst_n, r_calib_left != '0, r_seeded && !r_armed, "calibration count without seeding")
    `CTD_ASSERT_NEXT(a_seed_once, i_clk, i_rst_n, w_fire && !r_seeded, r_seeded && !r_armed && !r_out_valid, "seeding sample left the detector busy")

endmodule
